@@ rtl/core/skmd_pkg.sv @@
// ----------------------------------------------------------------------------
// skmd_pkg: shared definitions for the straight-key Morse decoder
// Sizes, register codes, event codes, result struct and the Morse table.
// ----------------------------------------------------------------------------
package skmd_pkg;

	localparam int MAX_SYMBOLS = 9;
	localparam int TIMER_BITS  = 12;
	localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
	localparam int CFG_W       = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int TEXT_W      = 7;
	localparam int CODE_W      = 7;
	localparam int CMP_W       = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam int TABLE_LEN   = 36;
	localparam int LETTERS     = 26;

	// output queue
	localparam int OQ_DEPTH    = 8;
	localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

	// register reset values
	localparam logic [CFG_W-1:0]  MIN_PRESS_RST = 12'd20;
	localparam logic [CFG_W-1:0]  DASH_MIN_RST  = 12'd250;
	localparam logic [CFG_W-1:0]  CHAR_GAP_RST  = 12'd750;
	localparam logic [CFG_W-1:0]  WORD_GAP_RST  = 12'd1750;
	localparam logic [TEXT_W-1:0] MAX_TEXT_RST  = 7'd99;

	localparam logic [CODE_W-1:0] CHAR_SLASH = 7'h2F;
	localparam logic [CODE_W-1:0] CHAR_QUERY = 7'h3F;
	localparam logic [CODE_W-1:0] CHAR_A     = 7'h41;
	localparam logic [CODE_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CODE_W-1:0] CHAR_NONE  = 7'h00;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_PRESS = 3'd0,
		REG_DASH_MIN  = 3'd1,
		REG_CHAR_GAP  = 3'd2,
		REG_WORD_GAP  = 3'd3,
		REG_MAX_TEXT  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		EV_CHAR  = 2'd0,
		EV_SEP   = 2'd1,
		EV_CLEAR = 2'd2,
		EV_EXIT  = 2'd3
	} event_kind_t;

	typedef struct packed {
		event_kind_t       kind;
		logic [CODE_W-1:0] code;
		logic              last;
	} result_t;

	// entry = length (4 bits) << 9 | pattern, bit i is symbol i, 1 = dash
	localparam logic [12:0] MORSE_TABLE [TABLE_LEN] = '{
		{4'd2, 9'd2},  {4'd4, 9'd1},  {4'd4, 9'd5},  {4'd3, 9'd1},  {4'd1, 9'd0},
		{4'd4, 9'd4},  {4'd3, 9'd3},  {4'd4, 9'd0},  {4'd2, 9'd0},  {4'd4, 9'd14},
		{4'd3, 9'd5},  {4'd4, 9'd2},  {4'd2, 9'd3},  {4'd2, 9'd1},  {4'd3, 9'd7},
		{4'd4, 9'd6},  {4'd4, 9'd11}, {4'd3, 9'd2},  {4'd3, 9'd0},  {4'd1, 9'd1},
		{4'd3, 9'd4},  {4'd4, 9'd8},  {4'd3, 9'd6},  {4'd4, 9'd9},  {4'd4, 9'd13},
		{4'd4, 9'd3},
		{4'd5, 9'd31}, {4'd5, 9'd30}, {4'd5, 9'd28}, {4'd5, 9'd24}, {4'd5, 9'd16},
		{4'd5, 9'd0},  {4'd5, 9'd1},  {4'd5, 9'd3},  {4'd5, 9'd7},  {4'd5, 9'd15}
	};

	// Look the held symbols up; no match gives '?'
	function automatic logic [CODE_W-1:0] morse_lookup(
		input logic [CNT_W-1:0]       cnt,
		input logic [MAX_SYMBOLS-1:0] bits
	);
		logic [CODE_W-1:0] c;
		logic              hit;
		c   = CHAR_QUERY;
		hit = 1'b0;
		for (int i = 0; i < TABLE_LEN; i++) begin
			if (!hit && cnt == CNT_W'(MORSE_TABLE[i][12:9])
			    && bits == MAX_SYMBOLS'(MORSE_TABLE[i][4:0])) begin
				hit = 1'b1;
				if (i < LETTERS)
					c = CHAR_A + CODE_W'(i);
				else
					c = CHAR_ZERO + CODE_W'(i - LETTERS);
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/core/skmd_if.sv @@
// ----------------------------------------------------------------------------
// skmd_if: item channels of the straight-key Morse decoder
// Tick channel (key and erase levels) and event channel, valid/ready.
// ----------------------------------------------------------------------------
interface skmd_in_if;
	logic valid;
	logic ready;
	logic key_down;
	logic erase_down;

	modport source (output valid, key_down, erase_down, input ready);
	modport sink (input valid, key_down, erase_down, output ready);
	modport monitor (input valid, ready, key_down, erase_down);
endinterface

interface skmd_out_if;
	import skmd_pkg::*;
	logic              valid;
	logic              ready;
	event_kind_t       event_kind;
	logic [CODE_W-1:0] char_code;
	logic              last;

	modport source (output valid, event_kind, char_code, last, input ready);
	modport sink (input valid, event_kind, char_code, last, output ready);
	modport monitor (input valid, ready, event_kind, char_code, last);
endinterface

@@ rtl/core/straight_key_morse_decoder.sv @@
// ----------------------------------------------------------------------------
// straight_key_morse_decoder: straight-key Morse decoder, one tick per item
// Times key presses and gaps, assembles dots and dashes, emits characters,
// word separators, clear and exit events.
// ----------------------------------------------------------------------------
// Usage:
//   samples carries one item per millisecond tick: key_down and erase_down.
//   events carries results: event_kind, char_code and last (set on the final
//   result of a tick). A tick gives zero, one or two results.
//   cfg_wr_en/cfg_idx/cfg_wdata write the thresholds and text limit; write
//   only while no tick is in flight and the event queue is empty.
// Timing:
//   A tick is registered at acceptance and processed in the next cycle; its
//   results are then written into the event queue, which drives events. One
//   tick per cycle is taken for as long as the 8-entry event queue has room
//   for the tick in flight and the new one.
// Reset:
//   arst_n clears timers, held symbols, text count and the queue, and loads
//   the register defaults.
// Stall:
//   While events.ready is low the queue fills and samples.ready drops once
//   it lacks room for two results of the tick in flight and two of a new
//   tick; nothing is lost.
// ----------------------------------------------------------------------------
module straight_key_morse_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [skmd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [skmd_pkg::CFG_W-1:0]    cfg_wdata,
	skmd_in_if.sink                       samples,
	skmd_out_if.source                    events
);
	import skmd_pkg::*;

	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

	// configuration
	logic [CFG_W-1:0]  min_press_q, dash_min_q, char_gap_q, word_gap_q;
	logic [TEXT_W-1:0] max_text_q;

	// input stage
	logic valid_s1, key_s1, erase_s1;

	// decoder state
	logic                   key_held_q, pending_q, last_sep_q;
	logic [TIMER_BITS-1:0]  press_q, gap_q;
	logic [CNT_W-1:0]       sym_cnt_q;
	logic [MAX_SYMBOLS-1:0] sym_bits_q;
	logic [TEXT_W-1:0]      emitted_q;

	// next state
	logic                   key_held_d, pending_d, last_sep_d;
	logic [TIMER_BITS-1:0]  press_d, gap_d, dur;
	logic [CNT_W-1:0]       sym_cnt_d;
	logic [MAX_SYMBOLS-1:0] sym_bits_d;
	logic [TEXT_W-1:0]      emitted_d;
	logic [CODE_W-1:0]      dec_char;
	logic                   tick_done;
	result_t                res0, res1;
	logic [1:0]             n_res, push_n;

	// event queue
	result_t               oq_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [OQ_CNT_W-1:0]   cnt_q;
	logic                  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_press_q <= MIN_PRESS_RST;
			dash_min_q  <= DASH_MIN_RST;
			char_gap_q  <= CHAR_GAP_RST;
			word_gap_q  <= WORD_GAP_RST;
			max_text_q  <= MAX_TEXT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_idx))
				REG_MIN_PRESS: min_press_q <= cfg_wdata;
				REG_DASH_MIN:  dash_min_q  <= cfg_wdata;
				REG_CHAR_GAP:  char_gap_q  <= cfg_wdata;
				REG_WORD_GAP:  word_gap_q  <= cfg_wdata;
				REG_MAX_TEXT:  max_text_q  <= cfg_wdata[TEXT_W-1:0];
				default: ;
			endcase
		end
	end

	assign samples.ready = (cnt_q + (valid_s1 ? OQ_CNT_W'(2) : '0))
	                       <= OQ_CNT_W'(OQ_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= samples.valid && samples.ready;
	end

	always_ff @(posedge clk) begin
		key_s1   <= samples.key_down;
		erase_s1 <= samples.erase_down;
	end

	always_comb begin
		press_d    = (press_q < TIMER_MAX) ? press_q + 1'b1 : press_q;
		gap_d      = (gap_q < TIMER_MAX) ? gap_q + 1'b1 : gap_q;
		key_held_d = key_held_q;
		pending_d  = pending_q;
		last_sep_d = last_sep_q;
		sym_cnt_d  = sym_cnt_q;
		sym_bits_d = sym_bits_q;
		emitted_d  = emitted_q;
		dur        = '0;
		dec_char   = CHAR_QUERY;
		tick_done  = 1'b0;
		n_res      = 2'd0;
		res0       = '{kind: EV_CHAR, code: CHAR_NONE, last: 1'b0};
		res1       = '{kind: EV_CHAR, code: CHAR_NONE, last: 1'b0};

		if (erase_s1) begin
			if (emitted_q != '0 || sym_cnt_q != '0) begin
				emitted_d  = '0;
				sym_cnt_d  = '0;
				sym_bits_d = '0;
				pending_d  = 1'b0;
				last_sep_d = 1'b0;
				res0       = '{kind: EV_CLEAR, code: CHAR_NONE, last: 1'b0};
				n_res      = 2'd1;
			end else begin
				// nothing pending: request exit and end the tick
				key_held_d = 1'b0;
				pending_d  = 1'b0;
				res0       = '{kind: EV_EXIT, code: CHAR_NONE, last: 1'b0};
				n_res      = 2'd1;
				tick_done  = 1'b1;
			end
		end

		if (!tick_done) begin
			if (key_s1 && !key_held_d) begin
				key_held_d = 1'b1;
				press_d    = '0;
			end else if (!key_s1 && key_held_d) begin
				dur        = press_d;
				key_held_d = 1'b0;
				gap_d      = '0;
				pending_d  = 1'b1;
				if (sym_cnt_d < CNT_W'(MAX_SYMBOLS)) begin
					if (CMP_W'(dur) > CMP_W'(min_press_q)
					    && CMP_W'(dur) < CMP_W'(dash_min_q)) begin
						sym_cnt_d = sym_cnt_d + 1'b1;
					end else if (CMP_W'(dur) >= CMP_W'(dash_min_q)) begin
						sym_bits_d = sym_bits_d | (MAX_SYMBOLS'(1) << sym_cnt_d);
						sym_cnt_d  = sym_cnt_d + 1'b1;
					end
				end
			end

			if (!key_s1 && pending_d && CMP_W'(gap_d) > CMP_W'(char_gap_q)
			    && sym_cnt_d != '0) begin
				dec_char = morse_lookup(sym_cnt_d, sym_bits_d);
				if (emitted_d < max_text_q) begin
					emitted_d  = emitted_d + 1'b1;
					last_sep_d = 1'b0;
					if (n_res == 2'd0)
						res0 = '{kind: EV_CHAR, code: dec_char, last: 1'b0};
					else
						res1 = '{kind: EV_CHAR, code: dec_char, last: 1'b0};
					n_res = n_res + 1'b1;
				end
				sym_cnt_d  = '0;
				sym_bits_d = '0;
				pending_d  = 1'b0;
			end

			if (!key_s1 && CMP_W'(gap_d) > CMP_W'(word_gap_q)
			    && emitted_d != '0 && !last_sep_d) begin
				if (emitted_d < max_text_q) begin
					emitted_d  = emitted_d + 1'b1;
					last_sep_d = 1'b1;
					if (n_res == 2'd0)
						res0 = '{kind: EV_SEP, code: CHAR_SLASH, last: 1'b0};
					else
						res1 = '{kind: EV_SEP, code: CHAR_SLASH, last: 1'b0};
					n_res = n_res + 1'b1;
				end
				gap_d = '0;
			end
		end

		if (n_res == 2'd1)
			res0.last = 1'b1;
		if (n_res == 2'd2)
			res1.last = 1'b1;
	end

	assign push_n = valid_s1 ? n_res : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_held_q <= 1'b0;
			pending_q  <= 1'b0;
			last_sep_q <= 1'b0;
			press_q    <= '0;
			gap_q      <= '0;
			sym_cnt_q  <= '0;
			sym_bits_q <= '0;
			emitted_q  <= '0;
		end else if (valid_s1) begin
			key_held_q <= key_held_d;
			pending_q  <= pending_d;
			last_sep_q <= last_sep_d;
			press_q    <= press_d;
			gap_q      <= gap_d;
			sym_cnt_q  <= sym_cnt_d;
			sym_bits_q <= sym_bits_d;
			emitted_q  <= emitted_d;
		end
	end

	// event queue
	assign pop = events.valid && events.ready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			oq_q[wr_ptr_q] <= res0;
		if (push_n == 2'd2)
			oq_q[wr_ptr_q + 1'b1] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + OQ_CNT_W'(push_n) - OQ_CNT_W'(pop);
		end
	end

	assign events.valid      = cnt_q != '0;
	assign events.event_kind = oq_q[rd_ptr_q].kind;
	assign events.char_code  = oq_q[rd_ptr_q].code;
	assign events.last       = oq_q[rd_ptr_q].last;

endmodule

@@ rtl/core/skmd_checker.sv @@
// ----------------------------------------------------------------------------
// skmd_checker: port-level checks for the straight-key Morse decoder
// Watches the tick and event channels and checks result ordering, contents and tick readiness.
// ----------------------------------------------------------------------------
module skmd_checker (
	input  logic           clk,
	input  logic           arst_n,
	skmd_in_if.sink        samples,
	skmd_out_if.source     events
);
	import skmd_pkg::*;

	logic in_acc;
	assign in_acc = samples.valid && samples.ready;

	// hold a stalled item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && !events.ready |=> events.valid
		&& $stable(events.event_kind) && $stable(events.char_code) && $stable(events.last))
		else $error("event changed while stalled");

	// clear and exit stand alone and carry no character
	a_ctrl_alone: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && (events.event_kind == EV_CLEAR || events.event_kind == EV_EXIT)
		|-> events.last && events.char_code == CHAR_NONE)
		else $error("clear or exit event malformed");

	// separator is always '/' and closes its tick
	a_sep_form: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && events.event_kind == EV_SEP
		|-> events.last && events.char_code == CHAR_SLASH)
		else $error("separator event malformed");

	// a character that is not last is followed at once by its separator
	a_char_pair: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && events.ready && events.event_kind == EV_CHAR && !events.last
		|=> events.valid && events.event_kind == EV_SEP)
		else $error("character not followed by separator");

	// the tick channel is never idle-blocked with an empty queue
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!events.valid && !$past(in_acc) |-> samples.ready)
		else $error("ready low with nothing queued");

endmodule

bind straight_key_morse_decoder skmd_checker u_skmd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.samples (samples),
	.events  (events)
);

@@ tb/morse_event_checker.sv @@
// ----------------------------------------------------------------------------
// morse_event_checker: event predictor and comparator for the Morse decoder
// Watches the tick and event channels and the register port, keeps its own
// copy of the decoder state, and compares every event against the oldest
// predicted one, field by field.
// ----------------------------------------------------------------------------
module morse_event_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [skmd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [skmd_pkg::CFG_W-1:0]     cfg_wdata,
	skmd_in_if.monitor                     samples,
	skmd_out_if.monitor                    events,
	output int                             errors,
	output int                             outstanding
);
	import skmd_pkg::*;

	localparam int unsigned TIMER_MAX = (1 << TIMER_BITS) - 1;

	string morse_pat [TABLE_LEN] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--..",
		"-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
		"---..", "----."
	};

	// thresholds and text limit
	int unsigned min_press, dash_min, char_gap, word_gap, max_text;

	// decoder state
	logic                   key_held, decode_pending, last_sep;
	int unsigned            press_t, gap_t, sym_cnt, emitted;
	logic [MAX_SYMBOLS-1:0] sym_bits;

	result_t pending_events [$];
	result_t want;

	function automatic logic [CODE_W-1:0] char_for(input int unsigned cnt,
		input logic [MAX_SYMBOLS-1:0] bits);
		logic [MAX_SYMBOLS-1:0] pat;
		for (int i = 0; i < TABLE_LEN; i++) begin
			pat = '0;
			for (int j = 0; j < morse_pat[i].len(); j++)
				if (morse_pat[i][j] == "-")
					pat[j] = 1'b1;
			if (morse_pat[i].len() == cnt && pat == bits)
				return (i < LETTERS) ? CHAR_A + CODE_W'(i) : CHAR_ZERO + CODE_W'(i - LETTERS);
		end
		return CHAR_QUERY;
	endfunction

	// Advance the decoder by one tick and queue the events it gives
	task automatic step_decoder(input logic key, input logic erase);
		result_t     evs [2];
		int          n;
		int unsigned dur;
		n = 0;
		if (press_t < TIMER_MAX)
			press_t++;
		if (gap_t < TIMER_MAX)
			gap_t++;
		if (erase && emitted == 0 && sym_cnt == 0) begin
			// nothing to clear: exit request ends the tick
			key_held       = 1'b0;
			decode_pending = 1'b0;
			evs[0]         = '{EV_EXIT, CHAR_NONE, 1'b0};
			n              = 1;
		end else begin
			if (erase) begin
				emitted        = 0;
				sym_cnt        = 0;
				sym_bits       = '0;
				decode_pending = 1'b0;
				last_sep       = 1'b0;
				evs[0]         = '{EV_CLEAR, CHAR_NONE, 1'b0};
				n              = 1;
			end
			if (key && !key_held) begin
				key_held = 1'b1;
				press_t  = 0;
			end else if (!key && key_held) begin
				dur            = press_t;
				key_held       = 1'b0;
				gap_t          = 0;
				decode_pending = 1'b1;
				if (sym_cnt < MAX_SYMBOLS) begin
					if (dur > min_press && dur < dash_min) begin
						sym_cnt++;
					end else if (dur >= dash_min) begin
						sym_bits[sym_cnt] = 1'b1;
						sym_cnt++;
					end
				end
			end
			if (!key && decode_pending && gap_t > char_gap && sym_cnt > 0) begin
				if (emitted < max_text) begin
					emitted++;
					last_sep = 1'b0;
					evs[n]   = '{EV_CHAR, char_for(sym_cnt, sym_bits), 1'b0};
					n++;
				end
				sym_cnt        = 0;
				sym_bits       = '0;
				decode_pending = 1'b0;
			end
			if (!key && gap_t > word_gap && emitted > 0 && !last_sep) begin
				if (emitted < max_text) begin
					emitted++;
					last_sep = 1'b1;
					evs[n]   = '{EV_SEP, CHAR_SLASH, 1'b0};
					n++;
				end
				gap_t = 0;
			end
		end
		for (int i = 0; i < n; i++) begin
			evs[i].last = (i == n - 1);
			pending_events.push_back(evs[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_press      = 32'(MIN_PRESS_RST);
			dash_min       = 32'(DASH_MIN_RST);
			char_gap       = 32'(CHAR_GAP_RST);
			word_gap       = 32'(WORD_GAP_RST);
			max_text       = 32'(MAX_TEXT_RST);
			key_held       = 1'b0;
			decode_pending = 1'b0;
			last_sep       = 1'b0;
			press_t        = 0;
			gap_t          = 0;
			sym_cnt        = 0;
			sym_bits       = '0;
			emitted        = 0;
			pending_events.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_idx))
					REG_MIN_PRESS: min_press = 32'(cfg_wdata);
					REG_DASH_MIN:  dash_min  = 32'(cfg_wdata);
					REG_CHAR_GAP:  char_gap  = 32'(cfg_wdata);
					REG_WORD_GAP:  word_gap  = 32'(cfg_wdata);
					REG_MAX_TEXT:  max_text  = 32'(cfg_wdata[TEXT_W-1:0]);
					default: ;
				endcase
			end
			if (samples.valid && samples.ready)
				step_decoder(samples.key_down, samples.erase_down);
			if (events.valid && events.ready) begin
				if (pending_events.size() == 0) begin
					errors++;
					$display("%0t: event with none predicted, expected none, got kind %0d code %0d last %0b",
						$time, events.event_kind, events.char_code, events.last);
				end else begin
					want = pending_events.pop_front();
					if (events.event_kind != want.kind) begin
						errors++;
						$display("%0t: event_kind mismatch, expected %0d, got %0d",
							$time, want.kind, events.event_kind);
					end
					if (events.char_code != want.code) begin
						errors++;
						$display("%0t: char_code mismatch, expected %0d, got %0d",
							$time, want.code, events.char_code);
					end
					if (events.last != want.last) begin
						errors++;
						$display("%0t: last mismatch, expected %0b, got %0b",
							$time, want.last, events.last);
					end
				end
			end
			outstanding <= pending_events.size();
		end
	end

endmodule

@@ tb/straight_key_morse_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// straight_key_morse_decoder_tb: testbench top for the Morse decoder
// Drives millisecond ticks (directed presses, timer extremes, then random
// characters and noise under several threshold settings) with random gaps on
// both channels and one long event stall; the checker predicts and compares.
// ----------------------------------------------------------------------------
module straight_key_morse_decoder_tb;
	import skmd_pkg::*;

	localparam int IDLE_PCT       = 16;
	localparam int RANDOM_TICKS   = 900;
	localparam int PHASE_TICKS    = 150;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int DRAIN_CYCLES   = 6;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;
	int                   errors;
	int                   outstanding;
	int                   ticks_sent;
	int                   events_seen;
	logic                 holdoff_go;
	logic                 tx_quiet;
	int unsigned          cur_min, cur_dash, cur_char_gap, cur_word_gap;

	skmd_in_if  samples_ch();
	skmd_out_if events_ch();

	straight_key_morse_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.samples   (samples_ch),
		.events    (events_ch)
	);

	morse_event_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.samples     (samples_ch),
		.events      (events_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("straight_key_morse_decoder_tb NOT OK");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			events_seen <= 0;
		else if (events_ch.valid && events_ch.ready)
			events_seen <= events_seen + 1;
	end

	// Event receiver: random stalls, a quiet stretch, and one long hold-off
	initial begin
		logic holdoff_done;
		holdoff_done = 1'b0;
		events_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holdoff_go && !holdoff_done) begin
				holdoff_done = 1'b1;
				events_ch.ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end
			events_ch.ready <= (events_seen >= 30 && events_seen < 60)
				|| ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic send_tick(input logic key, input logic erase);
		if (!tx_quiet && $urandom_range(99) < IDLE_PCT) begin
			samples_ch.valid <= 1'b0;
			@(posedge clk);
		end
		samples_ch.valid      <= 1'b1;
		samples_ch.key_down   <= key;
		samples_ch.erase_down <= erase;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
		ticks_sent++;
	endtask

	// Hold the key for len ticks, then release
	task automatic press(input int unsigned len);
		repeat (len) send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
	endtask

	task automatic key_up(input int unsigned n);
		repeat (n) send_tick(1'b0, 1'b0);
	endtask

	// Drop valid and wait until every predicted event has come out
	task automatic settle();
		samples_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input int unsigned min_press, input int unsigned dash_min,
		input int unsigned char_gap, input int unsigned word_gap, input int unsigned max_text);
		cur_min      = min_press;
		cur_dash     = dash_min;
		cur_char_gap = char_gap;
		cur_word_gap = word_gap;
		cfg_wr_en <= 1'b1;
		cfg_idx   <= REG_MIN_PRESS;
		cfg_wdata <= CFG_W'(min_press);
		@(posedge clk);
		cfg_idx   <= REG_DASH_MIN;
		cfg_wdata <= CFG_W'(dash_min);
		@(posedge clk);
		cfg_idx   <= REG_CHAR_GAP;
		cfg_wdata <= CFG_W'(char_gap);
		@(posedge clk);
		cfg_idx   <= REG_WORD_GAP;
		cfg_wdata <= CFG_W'(word_gap);
		@(posedge clk);
		cfg_idx   <= REG_MAX_TEXT;
		cfg_wdata <= CFG_W'(max_text);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int          phase;
		int          phase_start;
		int          random_start;
		int          n_sym;
		int unsigned len;
		int unsigned dash_len;
		int unsigned gap_len;
		int unsigned word_len;
		int unsigned text_len;
		arst_n                <= 1'b0;
		cfg_wr_en             <= 1'b0;
		cfg_idx               <= REG_MIN_PRESS;
		cfg_wdata             <= '0;
		samples_ch.valid      <= 1'b0;
		samples_ch.key_down   <= 1'b0;
		samples_ch.erase_down <= 1'b0;
		holdoff_go = 1'b0;
		tx_quiet   = 1'b0;
		ticks_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: short thresholds so characters come quickly
		set_config(1, 3, 2, 4, 127);
		send_tick(1'b0, 1'b1);                  // erase on idle: exit
		press(1);                               // too short, decode waits with no symbols
		key_up(4);
		press(2);
		key_up(1);
		press(3);
		key_up(6);                              // A, then separator
		repeat (5) press(3);
		key_up(3);                              // digit zero
		repeat (6) press(2);
		key_up(3);                              // no match
		repeat (10) press(2);
		key_up(3);                              // overflow of held symbols
		repeat (3) send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);                  // clear, then the release still counts
		key_up(3);
		repeat (2) send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b1);                  // clear with key down
		send_tick(1'b1, 1'b1);                  // nothing pending: exit, key dropped
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		key_up(3);
		settle();

		// word gap below char gap: character and separator on one tick
		set_config(1, 3, 3, 2, 127);
		press(2);
		key_up(4);
		settle();

		// text limit reached
		set_config(1, 3, 2, 20, 2);
		press(2);
		key_up(3);
		send_tick(1'b0, 1'b1);
		press(2);
		key_up(3);
		press(3);
		key_up(3);
		press(2);
		key_up(3);
		send_tick(1'b0, 1'b1);
		settle();

		// extremes: saturated press timer, largest thresholds
		set_config(4095, 4095, 1, 1, 127);
		press(4100);
		key_up(2);
		press(100);
		key_up(2);
		settle();

		// extremes: saturated gap timer never passes the largest gap
		set_config(0, 1, 4095, 4095, 0);
		press(1);
		key_up(4100);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b1);
		settle();

		set_config(0, 4095, 1, 4095, 0);
		press(2);
		key_up(3);
		send_tick(1'b0, 1'b1);
		settle();

		// random characters and noise under changing thresholds
		phase        = 0;
		random_start = ticks_sent;
		while (ticks_sent < random_start + RANDOM_TICKS) begin
			settle();
			len      = $urandom_range(0, 3);
			dash_len = len + $urandom_range(1, 5);
			gap_len  = $urandom_range(1, 8);
			word_len = ($urandom_range(3) == 0) ? $urandom_range(1, gap_len)
				: gap_len + $urandom_range(1, 10);
			text_len = ($urandom_range(4) == 0) ? $urandom_range(0, 10) : $urandom_range(40, 127);
			if (phase == 1)
				text_len = 127;
			set_config(len, dash_len, gap_len, word_len, text_len);
			if (phase == 1)
				holdoff_go = 1'b1;
			tx_quiet    = (phase == 2);
			phase_start = ticks_sent;
			while (ticks_sent < phase_start + PHASE_TICKS) begin
				case ($urandom_range(0, 9)) inside
					[0:7]: begin
						n_sym = ($urandom_range(99) < 85) ? $urandom_range(1, 5)
							: $urandom_range(6, 11);
						for (int i = 0; i < n_sym; i++) begin
							if ($urandom_range(99) < 10)
								len = $urandom_range(1, cur_dash + 2);
							else if ($urandom_range(1))
								len = cur_dash + $urandom_range(0, 2);
							else if (cur_min + 1 < cur_dash)
								len = $urandom_range(cur_min + 1, cur_dash - 1);
							else
								len = cur_min + 1;
							press(len);
							if (i < n_sym - 1)
								key_up($urandom_range(0, cur_char_gap));
						end
						key_up($urandom_range(cur_char_gap + 1, cur_char_gap + cur_word_gap + 2));
					end
					8: repeat ($urandom_range(1, 8))
						send_tick(1'($urandom_range(1)), $urandom_range(15) == 0);
					default: send_tick(1'($urandom_range(1)), 1'b1);
				endcase
			end
			tx_quiet = 1'b0;
			phase++;
		end

		settle();
		if (errors == 0)
			$display("straight_key_morse_decoder_tb OK");
		else
			$display("straight_key_morse_decoder_tb NOT OK");
		$finish;
	end

endmodule
